FILE: rtl/assert_macros.svh
// Assertion macros shared by the responder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i, off while rst_ni is low.
`define MBRR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Same check with a caller-supplied message.
`define MBRR_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

FILE: rtl/mbrr_pkg.sv
// Shared constants, types and CRC function of the register read responder.
`timescale 1ns / 1ps
package mbrr_pkg;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] WantStart = 16'h0001;
  localparam logic [15:0] WantCount = 16'h0004;
  localparam logic [3:0]  MinFrame  = 4'd8;
  localparam logic [3:0]  CrcLowIdx = 4'd11;
  localparam logic [3:0]  ReplyLast = 4'd12;
  localparam logic [7:0]  ByteCount = 8'd8;
  localparam int          QueueDepth = 2;

  localparam logic CfgStation  = 1'b0;
  localparam logic CfgFunction = 1'b1;

  typedef struct packed {
    logic [15:0]        soil_percent;
    logic [15:0]        dust_reading;
    logic [15:0]        light_lux;
    logic signed [15:0] temperature_tenths;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/mbrr_front.sv
// Request parser: running CRC, byte count, header capture and frame check.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbrr_front import mbrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  input  job_t       job_i,
  input  logic [7:0] station_i,
  input  logic [7:0] function_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [15:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  stn_q, stn_d;
  logic [7:0]  fn_q, fn_d;
  logic [15:0] start_q, start_d;
  logic [15:0] count_q, count_d;
  logic        acc;
  logic        ok;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign job_o      = job_i;

  always_comb begin
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    stn_d   = stn_q;
    fn_d    = fn_q;
    start_d = start_q;
    count_d = count_q;
    ok      = 1'b0;
    push_o  = 1'b0;
    if (acc) begin
      case (cnt_q)
        4'd0:    stn_d = rx_byte_i;
        4'd1:    fn_d = rx_byte_i;
        4'd2:    start_d[15:8] = rx_byte_i;
        4'd3:    start_d[7:0] = rx_byte_i;
        4'd4:    count_d[15:8] = rx_byte_i;
        4'd5:    count_d[7:0] = rx_byte_i;
        default: ;
      endcase
      crc_d = crc_feed(crc_q, rx_byte_i);
      if (cnt_q < MinFrame) begin
        cnt_d = cnt_q + 4'd1;
      end
      ok = (cnt_d == MinFrame) && (crc_d == 16'h0000) && (stn_d == station_i) &&
           (fn_d == function_i) && (start_d == WantStart) && (count_d == WantCount);
      if (frame_end_i) begin
        push_o  = ok;
        crc_d   = CrcInit;
        cnt_d   = '0;
        stn_d   = '0;
        fn_d    = '0;
        start_d = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      cnt_q   <= '0;
      stn_q   <= '0;
      fn_q    <= '0;
      start_q <= '0;
      count_q <= '0;
    end else begin
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      stn_q   <= stn_d;
      fn_q    <= fn_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  `MBRR_ASSERT(frame_clears, (acc && frame_end_i) |=> (cnt_q == '0 && crc_q == CrcInit))

endmodule

FILE: rtl/mbrr_fifo.sv
// Short job queue between the request parser and the reply serialiser.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbrr_fifo import mbrr_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

  `MBRR_ASSERT_MSG(no_overflow, push_i |-> !full_o, "job pushed into a full queue")
  `MBRR_ASSERT(count_bound, cnt_q <= CW'(Depth))

endmodule

FILE: rtl/mbrr_back.sv
// Reply serialiser: emits the 13-byte reply with its CRC through an output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbrr_back import mbrr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  job_t       job_i,
  output logic       pop_o,
  input  logic [7:0] station_i,
  input  logic [7:0] function_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic        busy_q;
  logic [3:0]  idx_q;
  job_t        job_q;
  logic [15:0] crc_q;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic        ol_q;
  logic        adv;
  logic [7:0]  cur_b;

  assign pop_o       = !busy_q && valid_i;
  assign adv         = busy_q && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

  always_comb begin
    case (idx_q)
      4'd0:    cur_b = station_i;
      4'd1:    cur_b = function_i;
      4'd2:    cur_b = ByteCount;
      4'd3:    cur_b = job_q.temperature_tenths[15:8];
      4'd4:    cur_b = job_q.temperature_tenths[7:0];
      4'd5:    cur_b = job_q.light_lux[15:8];
      4'd6:    cur_b = job_q.light_lux[7:0];
      4'd7:    cur_b = job_q.dust_reading[15:8];
      4'd8:    cur_b = job_q.dust_reading[7:0];
      4'd9:    cur_b = job_q.soil_percent[15:8];
      4'd10:   cur_b = job_q.soil_percent[7:0];
      4'd11:   cur_b = crc_q[7:0];
      default: cur_b = crc_q[15:8];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (adv) begin
        idx_q <= idx_q + 4'd1;
        if (idx_q == ReplyLast) begin
          busy_q <= 1'b0;
        end
      end
      if (adv) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      crc_q <= CrcInit;
    end
    if (adv) begin
      ob_q <= cur_b;
      ol_q <= (idx_q == ReplyLast);
      if (idx_q < CrcLowIdx) begin
        crc_q <= crc_feed(crc_q, cur_b);
      end
    end
  end

  `MBRR_ASSERT(idx_bound, !(busy_q && idx_q > ReplyLast))
  `MBRR_ASSERT(last_word, (adv && idx_q == ReplyLast) |=> (!busy_q && ov_q && ol_q))

endmodule

FILE: rtl/modbus_rtu_read_responder.sv
// Top level of the register read responder: config registers, parser, queue, serialiser.
// Usage:
//   Request bytes enter on the s_axis channel, one word per byte; s_axis_tlast
//   marks the last byte of a frame and the four sensor words in s_axis_tdata
//   are sampled with that byte. The block accepts one word every cycle while
//   its job queue has room (QDepth accepted frames waiting to be answered).
//   A frame that passes length, CRC, station, function, start register and
//   register count checks yields a 13-byte reply on m_axis; m_axis_tlast marks
//   its final byte. Rejected frames give nothing.
//   Output: m_axis_tvalid rises once an accepted frame's job has passed the queue,
//   the serialiser start and the output register; the bytes follow one per cycle
//   while m_axis_tready is high; a new job starts only after the prior reply ends.
//   A stalled receiver holds the output register; the serialiser stops, and
//   the parser keeps taking bytes until the queue is full.
//   The config port writes station address (index 0) and function code
//   (index 1) on cycles with cfg_we_i high; write only while idle.
//   Reset clears the frame state, empties the queue and drops any reply in
//   progress; station address returns to 1 and function code to 3.
`timescale 1ns / 1ps
module modbus_rtu_read_responder import mbrr_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [23:8] temperature_tenths, [39:24] light_lux,
  // [55:40] dust_reading, [71:56] soil_percent
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic [7:0] station_q;
  logic [7:0] function_q;
  job_t       in_job;
  job_t       push_job;
  job_t       head_job;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q  <= 8'd1;
      function_q <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStation:  station_q <= cfg_wdata_i;
        CfgFunction: function_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  assign in_job.temperature_tenths = s_axis_tdata[23:8];
  assign in_job.light_lux          = s_axis_tdata[39:24];
  assign in_job.dust_reading       = s_axis_tdata[55:40];
  assign in_job.soil_percent       = s_axis_tdata[71:56];

  mbrr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .frame_end_i (s_axis_tlast),
    .job_i       (in_job),
    .station_i   (station_q),
    .function_i  (function_q),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  mbrr_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  mbrr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .station_i   (station_q),
    .function_i  (function_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the register read responder: directed request frames, then random traffic.
`timescale 1ns / 1ps
module tb_top;
  import mbrr_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 134;
  localparam int DIR_ROWS     = 25;
  localparam int REPLY_BYTES  = 13;

  typedef enum logic [1:0] {SRC_LITERAL, SRC_CRC_LOW, SRC_CRC_HIGH} byte_src_e;
  typedef enum logic {WANT_PREDICTED, WANT_NO_REPLY} row_want_e;
  typedef enum logic [3:0] {
    FR_GOOD, FR_LONG, FR_BAD_CRC, FR_BAD_STATION, FR_BAD_FUNCTION,
    FR_BAD_START, FR_BAD_QUANTITY, FR_SHORT, FR_NOISE
  } frame_kind_e;

  typedef struct packed {
    byte_src_e  src;
    logic [7:0] value;
    logic       last;
    row_want_e  want;
    job_t       sensors;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_word_t;

  // soil, dust, light, temperature from the top bits down
  localparam job_t SENSE_A = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000};
  localparam job_t SENSE_B = {16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;

  modbus_rtu_read_responder dut (.*);

  logic [7:0]  own_station  = 8'd1;
  logic [7:0]  own_function = 8'd3;
  logic [15:0] req_crc;
  logic [3:0]  req_len;
  logic [7:0]  req_station;
  logic [7:0]  req_function;
  logic [15:0] req_start;
  logic [15:0] req_quantity;
  logic [7:0]  reply_bytes [REPLY_BYTES];

  tx_word_t  expected_tx [$];
  stim_row_t dir_rows [DIR_ROWS];

  int send_idle   = 33;
  int recv_idle   = 80;
  int items_sent  = 0;
  int frames_sent = 0;
  int replies_seen = 0;
  int mismatches  = 0;
  int cycle_count = 0;

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CrcPoly;
    end
    return crc;
  endfunction

  function automatic void clear_request();
    req_crc      = CrcInit;
    req_len      = '0;
    req_station  = '0;
    req_function = '0;
    req_start    = '0;
    req_quantity = '0;
  endfunction

  // returns the number of reply bytes left in reply_bytes
  function automatic int advance_request(logic [7:0] b, logic last, job_t s);
    logic        accept;
    logic [15:0] crc;
    logic [15:0] words [4];
    case (req_len)
      4'd0: req_station = b;
      4'd1: req_function = b;
      4'd2: req_start[15:8] = b;
      4'd3: req_start[7:0] = b;
      4'd4: req_quantity[15:8] = b;
      4'd5: req_quantity[7:0] = b;
      default: ;
    endcase
    req_crc = crc16_step(req_crc, b);
    if (req_len < MinFrame) req_len = req_len + 4'd1;
    if (!last) return 0;
    accept = req_len >= MinFrame && req_crc == 16'h0000 &&
             req_station == own_station && req_function == own_function &&
             req_start == WantStart && req_quantity == WantCount;
    clear_request();
    if (!accept) return 0;
    words[0] = s.temperature_tenths;
    words[1] = s.light_lux;
    words[2] = s.dust_reading;
    words[3] = s.soil_percent;
    reply_bytes[0] = own_station;
    reply_bytes[1] = own_function;
    reply_bytes[2] = ByteCount;
    for (int i = 0; i < 4; i++) begin
      reply_bytes[3 + 2 * i] = words[i][15:8];
      reply_bytes[4 + 2 * i] = words[i][7:0];
    end
    crc = CrcInit;
    for (int i = 0; i < CrcLowIdx; i++) crc = crc16_step(crc, reply_bytes[i]);
    reply_bytes[CrcLowIdx] = crc[7:0];
    reply_bytes[ReplyLast] = crc[15:8];
    return REPLY_BYTES;
  endfunction

  function automatic stim_row_t stim_row(byte_src_e src, logic [7:0] value, logic last,
                                         row_want_e want, job_t sensors);
    stim_row_t r;
    r.src     = src;
    r.value   = value;
    r.last    = last;
    r.want    = want;
    r.sensors = sensors;
    return r;
  endfunction

  task automatic send_word(logic [7:0] b, logic last, job_t sensors, logic no_reply_typed);
    int n;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sensors, b};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n = advance_request(b, last, sensors);
    if (!no_reply_typed)
      for (int i = 0; i < n; i++)
        expected_tx.push_back(tx_word_t'({reply_bytes[i], i == ReplyLast}));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(frame_kind_e kind);
    logic [7:0]  fb [16];
    logic [7:0]  flip;
    logic [15:0] crc;
    int          len;
    int          pos;
    flip  = 8'($urandom_range(1, 255));
    fb[0] = own_station;
    fb[1] = own_function;
    fb[2] = WantStart[15:8];
    fb[3] = WantStart[7:0];
    fb[4] = WantCount[15:8];
    fb[5] = WantCount[7:0];
    len   = 6;
    case (kind)
      FR_BAD_STATION:  fb[0] = fb[0] ^ flip;
      FR_BAD_FUNCTION: fb[1] = fb[1] ^ flip;
      FR_BAD_START: begin
        pos = 2 + $urandom_range(1);
        fb[pos] = fb[pos] ^ flip;
      end
      FR_BAD_QUANTITY: begin
        pos = 4 + $urandom_range(1);
        fb[pos] = fb[pos] ^ flip;
      end
      FR_LONG: begin
        repeat ($urandom_range(1, 3)) begin
          fb[len] = 8'($urandom_range(255));
          len++;
        end
      end
      FR_NOISE: begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) fb[i] = 8'($urandom_range(255));
      end
      default: ;
    endcase
    if (kind != FR_NOISE) begin
      crc = CrcInit;
      for (int i = 0; i < len; i++) crc = crc16_step(crc, fb[i]);
      fb[len]     = crc[7:0];
      fb[len + 1] = crc[15:8];
      len += 2;
    end
    if (kind == FR_BAD_CRC) begin
      pos = len - 1 - $urandom_range(1);
      fb[pos] = fb[pos] ^ flip;
    end
    if (kind == FR_SHORT) len = $urandom_range(1, 7);
    for (int i = 0; i < len; i++)
      send_word(fb[i], i == len - 1, {$urandom, $urandom}, 1'b0);
    frames_sent++;
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (expected_tx.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_settings(logic [7:0] station, logic [7:0] func);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgStation;
    cfg_wdata_i <= station;
    @(negedge clk_i);
    cfg_idx_i   <= CfgFunction;
    cfg_wdata_i <= func;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    own_station  = station;
    own_function = func;
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin : reply_monitor
    tx_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tx.size() == 0) begin
        $error("unexpected reply word: tx_byte %0h tx_last %0b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_tx.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("tx_byte: expected %0h, actual %0h", want.data, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("tx_last: expected %0b, actual %0b", want.last, m_axis_tlast);
          mismatches++;
        end
        if (want.last) replies_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_rows[0]  = stim_row(SRC_LITERAL,  8'h01, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[1]  = stim_row(SRC_LITERAL,  8'h03, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[2]  = stim_row(SRC_LITERAL,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[3]  = stim_row(SRC_LITERAL,  8'h01, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[4]  = stim_row(SRC_LITERAL,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[5]  = stim_row(SRC_LITERAL,  8'h04, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[6]  = stim_row(SRC_CRC_LOW,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[7]  = stim_row(SRC_CRC_HIGH, 8'h00, 1'b1, WANT_PREDICTED, SENSE_A);
    dir_rows[8]  = stim_row(SRC_LITERAL,  8'hFF, 1'b1, WANT_NO_REPLY,  SENSE_B);
    dir_rows[9]  = stim_row(SRC_LITERAL,  8'h01, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[10] = stim_row(SRC_LITERAL,  8'h03, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[11] = stim_row(SRC_LITERAL,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[12] = stim_row(SRC_LITERAL,  8'h01, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[13] = stim_row(SRC_LITERAL,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[14] = stim_row(SRC_LITERAL,  8'h04, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[15] = stim_row(SRC_LITERAL,  8'hFF, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[16] = stim_row(SRC_CRC_LOW,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[17] = stim_row(SRC_CRC_HIGH, 8'h00, 1'b1, WANT_PREDICTED, SENSE_B);
    dir_rows[18] = stim_row(SRC_LITERAL,  8'h01, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[19] = stim_row(SRC_LITERAL,  8'h03, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[20] = stim_row(SRC_LITERAL,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[21] = stim_row(SRC_LITERAL,  8'h01, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[22] = stim_row(SRC_LITERAL,  8'h00, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[23] = stim_row(SRC_LITERAL,  8'h04, 1'b0, WANT_NO_REPLY,  '0);
    dir_rows[24] = stim_row(SRC_CRC_LOW,  8'h00, 1'b1, WANT_NO_REPLY,  SENSE_A);
  end

  initial begin : stimulus
    logic [15:0] row_crc;
    logic [7:0]  row_byte;
    int          pick;
    int          phase_start;
    frame_kind_e kind;
    clear_request();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    row_crc = CrcInit;
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (dir_rows[r].src)
        SRC_CRC_LOW:  row_byte = row_crc[7:0];
        SRC_CRC_HIGH: row_byte = row_crc[15:8];
        default: begin
          row_byte = dir_rows[r].value;
          row_crc  = crc16_step(row_crc, row_byte);
        end
      endcase
      send_word(row_byte, dir_rows[r].last, dir_rows[r].sensors,
                dir_rows[r].want == WANT_NO_REPLY);
      if (dir_rows[r].last) row_crc = CrcInit;
    end

    for (int p = 0; p < 3; p++) begin
      drain_replies();
      write_settings(p == 0 ? 8'd247 : p == 1 ? 8'd1 : 8'h5A,
                     p == 0 ? 8'd0 : p == 1 ? 8'd255 : 8'd3);
      send_idle = (p == 0) ? 33 : (p == 1) ? 80 : 0;
      recv_idle = (p == 0) ? 80 : (p == 1) ? 33 : 0;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(99);
        kind = pick < 45 ? FR_GOOD :
               pick < 55 ? FR_LONG :
               pick < 62 ? FR_BAD_CRC :
               pick < 67 ? FR_BAD_STATION :
               pick < 72 ? FR_BAD_FUNCTION :
               pick < 77 ? FR_BAD_START :
               pick < 82 ? FR_BAD_QUANTITY :
               pick < 90 ? FR_SHORT : FR_NOISE;
        send_frame(kind);
      end
    end
    drain_replies();

    $display("%0d request words in %0d random frames plus directed frames; %0d replies checked",
             items_sent, frames_sent, replies_seen);
    $display("covered three idle patterns and four address/function settings incl. extremes");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mbrr_pkg.sv
rtl/mbrr_front.sv
rtl/mbrr_fifo.sv
rtl/mbrr_back.sv
rtl/modbus_rtu_read_responder.sv
tb/tb_top.sv
